@@ rtl/ipv4p_pkg.sv @@
// Package for the IPv4 dotted-quad parser: status and field error codes,
// character constants, the shared result struct and the field check.
// No dependencies.
package ipv4p_pkg;

  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNine      = 8'h39;
  localparam logic [7:0] CharDot       = 8'h2E;
  localparam logic [9:0] OctetMax      = 10'd255;
  localparam logic [2:0] MaxDigits     = 3'd3;
  localparam logic [2:0] DigitsSat     = 3'd4;
  localparam logic [2:0] DotsSat       = 3'd7;
  localparam logic [2:0] DotsRequired  = 3'd3;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ILLEGAL_CHAR = 3'd1,
    ST_DOT_COUNT    = 3'd2,
    ST_EMPTY_LONG   = 3'd3,
    ST_LEADING_ZERO = 3'd4,
    ST_OVER_255     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FE_NONE       = 2'd0,
    FE_EMPTY_LONG = 2'd1,
    FE_LEAD_ZERO  = 2'd2,
    FE_OVER_255   = 2'd3
  } field_err_e;

  typedef struct packed {
    logic [31:0] address;
    status_e     status;
  } result_t;

  function automatic field_err_e close_err(input logic [2:0] digits,
                                           input logic       lead_zero,
                                           input logic [9:0] value);
    field_err_e err;
    err = FE_NONE;
    if (digits == 3'd0 || digits > MaxDigits) begin
      err = FE_EMPTY_LONG;
    end else if (digits > 3'd1 && lead_zero) begin
      err = FE_LEAD_ZERO;
    end else if (value > OctetMax) begin
      err = FE_OVER_255;
    end
    return err;
  endfunction

endpackage

@@ rtl/ipv4p_acc.sv @@
// Per-character parse state for the IPv4 parser: field accumulator, dot
// count, error tracking and the result of the closing character.
// Depends on ipv4p_pkg.
module ipv4p_acc import ipv4p_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output result_t    result_o
);

  logic [9:0]  value_q, value_d;
  logic [2:0]  digits_q, digits_d;
  logic        lz_q, lz_d;
  logic [2:0]  dots_q, dots_d;
  logic        ill_q, ill_d;
  field_err_e  fe_q, fe_d;
  logic [31:0] acc_q, acc_d;

  logic        is_digit, is_dot;
  logic [13:0] mac;
  field_err_e  err_last, fe_fin;
  logic [31:0] acc_fin;

  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign is_dot   = (char_i == CharDot);
  assign mac      = {4'd0, value_q} * 14'd10 + {6'd0, char_i - CharZero};

  always_comb begin
    value_d  = value_q;
    digits_d = digits_q;
    lz_d     = lz_q;
    dots_d   = dots_q;
    ill_d    = ill_q;
    fe_d     = fe_q;
    acc_d    = acc_q;
    if (is_digit) begin
      if (digits_q < DigitsSat) begin
        digits_d = digits_q + 3'd1;
        if (digits_q == 3'd0 && char_i == CharZero) begin
          lz_d = 1'b1;
        end
        if (digits_q < MaxDigits) begin
          value_d = mac[9:0];
        end
      end
    end else if (is_dot) begin
      if (fe_q == FE_NONE) begin
        fe_d = close_err(digits_q, lz_q, value_q);
      end
      acc_d    = {acc_q[23:0], value_q[7:0]};
      value_d  = '0;
      digits_d = '0;
      lz_d     = 1'b0;
      if (dots_q < DotsSat) begin
        dots_d = dots_q + 3'd1;
      end
    end else begin
      ill_d = 1'b1;
    end
  end

  // close the final field on top of the updated state
  always_comb begin
    err_last = close_err(digits_d, lz_d, value_d);
    fe_fin   = (fe_d == FE_NONE) ? err_last : fe_d;
    acc_fin  = {acc_d[23:0], value_d[7:0]};
    result_o.address = '0;
    if (ill_d) begin
      result_o.status = ST_ILLEGAL_CHAR;
    end else if (dots_d != DotsRequired) begin
      result_o.status = ST_DOT_COUNT;
    end else begin
      unique case (fe_fin)
        FE_NONE: begin
          result_o.status  = ST_OK;
          result_o.address = acc_fin;
        end
        FE_EMPTY_LONG: result_o.status = ST_EMPTY_LONG;
        FE_LEAD_ZERO:  result_o.status = ST_LEADING_ZERO;
        FE_OVER_255:   result_o.status = ST_OVER_255;
        default:       result_o.status = ST_EMPTY_LONG;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q  <= '0;
      digits_q <= '0;
      lz_q     <= 1'b0;
      dots_q   <= '0;
      ill_q    <= 1'b0;
      fe_q     <= FE_NONE;
      acc_q    <= '0;
    end else if (en_i) begin
      if (last_i) begin
        value_q  <= '0;
        digits_q <= '0;
        lz_q     <= 1'b0;
        dots_q   <= '0;
        ill_q    <= 1'b0;
        fe_q     <= FE_NONE;
        acc_q    <= '0;
      end else begin
        value_q  <= value_d;
        digits_q <= digits_d;
        lz_q     <= lz_d;
        dots_q   <= dots_d;
        ill_q    <= ill_d;
        fe_q     <= fe_d;
        acc_q    <= acc_d;
      end
    end
  end

endmodule

@@ rtl/ipv4_dotted_decimal_parser.sv @@
// Top level of the IPv4 dotted-quad parser: input register, parse state
// and result register with valid/ready transfers on both sides.
// Depends on ipv4p_pkg and ipv4p_acc.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | char_code_i[7:0], last_char_i
//   out     | output    | out_valid_o/out_ready_i| address_o[31:0], status_o[2:0]
//
// One character per cycle unless the input side is held; a result is offered
// once its last character has transferred into the input register and has then
// been processed, with no stall, into the result register.
// Reset clears the parse state and both valid flags.
// Only a last character waiting on a full, stalled result register holds
// the input side; other characters keep flowing.
module ipv4_dotted_decimal_parser import ipv4p_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] address_o,
  output logic [2:0]  status_o
);

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       stall, proc_en;
  logic       out_valid_q;
  result_t    res_d, res_q;

  assign stall      = in_valid_q && last_q && out_valid_q && !out_ready_i;
  assign proc_en    = in_valid_q && !stall;
  assign in_ready_o = !in_valid_q || !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  ipv4p_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (proc_en),
    .char_i   (char_q),
    .last_i   (last_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_en && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = res_q.address;
  assign status_o    = res_q.status;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> address_o == 32'd0)
    else $error("address not zero on error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_en && last_q))
    else $error("result without a closing character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && last_q && out_valid_q && !out_ready_i)
    else $error("input held without a pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

endmodule
